/* sv/bra_pkg.sv */
// shared types, codes and reset constants for the bump region allocator
// no dependencies
`default_nettype none
package bra_pkg;
    localparam int unsigned SLOTS_DEF = 32;

    localparam logic [31:0] PAGE_BIG_M1   = 32'h000F_FFFF;
    localparam logic [31:0] PAGE_SMALL_M1 = 32'h0000_FFFF;
    localparam logic [20:0] PAGE_BIG      = 21'h10_0000;
    localparam logic [20:0] PAGE_SMALL    = 21'h01_0000;

    localparam logic [31:0] RST_BASE      = 32'h4000_0000;
    localparam logic [31:0] RST_END       = 32'h5000_0000;
    localparam logic [31:0] RST_BUDGET    = 32'd223346688;
    localparam logic [31:0] RST_FOOTPRINT = 32'h017E_0000;

    localparam logic [2:0] CMD_ALLOC  = 3'd0;
    localparam logic [2:0] CMD_FREE   = 3'd1;
    localparam logic [2:0] CMD_QUERY  = 3'd2;
    localparam logic [2:0] CMD_LOOKUP = 3'd3;
    localparam logic [2:0] CMD_RESERVE = 3'd4;
    localparam logic [2:0] CMD_CHARGE = 3'd5;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_INVAL = 2'd1;
    localparam logic [1:0] ST_NOMEM = 2'd2;

    localparam logic [1:0] PCODE_SMALL   = 2'd2;
    localparam logic [1:0] PCODE_INVALID = 2'd3;

    localparam logic [2:0] REG_ACCT      = 3'd0;
    localparam logic [2:0] REG_BASE      = 3'd1;
    localparam logic [2:0] REG_END       = 3'd2;
    localparam logic [2:0] REG_BUDGET    = 3'd3;
    localparam logic [2:0] REG_FOOTPRINT = 3'd4;

    typedef struct packed {
        logic        valid;
        logic [31:0] start;
        logic [31:0] length;
        logic        big;
    } t_slot_rd;

    typedef struct packed {
        logic        we;
        logic        clr;
        logic [31:0] start;
        logic [31:0] length;
        logic        big;
    } t_slot_wr;
endpackage
`default_nettype wire

/* sv/bra_in_if.sv */
// command channel interface for the bump region allocator
// no dependencies
`default_nettype none
interface bra_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  cmd;
    logic [31:0] req_size;
    logic [1:0]  page_code;
    logic [31:0] align_bytes;
    logic [31:0] query_addr;
    modport source (output valid, cmd, req_size, page_code, align_bytes, query_addr,
                    input ready);
    modport sink (input valid, cmd, req_size, page_code, align_bytes, query_addr,
                  output ready);
endinterface
`default_nettype wire

/* sv/bra_out_if.sv */
// result channel interface for the bump region allocator
// no dependencies
`default_nettype none
interface bra_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [31:0] granted_addr;
    logic [31:0] budget_total;
    logic [31:0] budget_avail;
    logic [20:0] found_page_size;
    modport source (output valid, status, granted_addr, budget_total, budget_avail,
                    found_page_size, input ready);
    modport sink (input valid, status, granted_addr, budget_total, budget_avail,
                  found_page_size, output ready);
endinterface
`default_nettype wire

/* sv/bump_region_allocator.sv */
// top level: command sequencer around one shared 41-bit add/subtract unit
// depends on bra_pkg, bra_in_if, bra_out_if, bra_slot_table
//
//  channel | dir | handshake     | beat contents
//  in_ch   | in  | valid/ready   | cmd, req_size, page_code, align_bytes, query_addr
//  out_ch  | out | valid/ready   | status, granted_addr, budget_total, budget_avail,
//          |     |               | found_page_size
//  cfg     | in  | i_cfg_we only | i_cfg_idx, i_cfg_data
//
// allocate, free and lookup walk the slot table (one slot per cycle); every command
// steps through its sequencer states in turn, as the shared adder sets these
// ready is high only when the sequencer is idle and no result beat is pending
// synchronous active-low reset; slot valid flags clear at once, no sweep
`default_nettype none
module bump_region_allocator
    import bra_pkg::*;
#(
    parameter int unsigned SLOTS = SLOTS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [31:0] i_cfg_data,
    bra_in_if.sink           in_ch,
    bra_out_if.source        out_ch
);
    localparam int unsigned IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [IW-1:0] LAST = IW'(SLOTS - 1);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_SIZE = 4'd1;
    localparam logic [3:0] S_PTR  = 4'd2;
    localparam logic [3:0] S_WIN  = 4'd3;
    localparam logic [3:0] S_BUD0 = 4'd4;
    localparam logic [3:0] S_BUD1 = 4'd5;
    localparam logic [3:0] S_SCAN = 4'd6;
    localparam logic [3:0] S_AL0  = 4'd7;
    localparam logic [3:0] S_AL1  = 4'd8;
    localparam logic [3:0] S_FREE = 4'd9;
    localparam logic [3:0] S_Q0   = 4'd10;
    localparam logic [3:0] S_Q1   = 4'd11;
    localparam logic [3:0] S_Q2   = 4'd12;
    localparam logic [3:0] S_CHG  = 4'd13;
    localparam logic [3:0] S_DONE = 4'd14;

    logic        r_acct;
    logic [31:0] r_wend, r_budget, r_fcharge;
    logic [31:0] r_nfa, r_own;
    logic [39:0] r_ext;
    logic        r_fdone;

    logic [3:0]  r_state;
    logic [2:0]  r_cmd;
    logic [31:0] r_req, r_am1, r_addr;
    logic [1:0]  r_pcode;
    logic [32:0] r_size;
    logic [40:0] r_tmp;
    logic [IW-1:0] r_idx;

    logic        r_out_valid;
    logic [1:0]  r_status;
    logic [31:0] r_granted, r_total, r_avail;
    logic [20:0] r_psize;

    // shared adder
    logic [40:0] op_a, op_b;
    logic        op_sub;
    logic [41:0] sum;
    assign sum = {1'b0, op_a} + {1'b0, (op_sub ? ~op_b : op_b)} + {41'd0, op_sub};

    t_slot_rd slot_rd;
    t_slot_wr slot_wr;

    bra_slot_table #(.SLOTS(SLOTS)) u_slots (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_idx   (r_idx),
        .i_wr    (slot_wr),
        .o_rd    (slot_rd)
    );

    logic        in_fire;
    logic [32:0] amask;
    logic [32:0] aligned;
    logic [39:0] ext_sat;
    assign in_fire = in_ch.valid && in_ch.ready;
    assign amask   = {1'b1, ~r_am1};
    assign aligned = sum[32:0] & amask;
    assign ext_sat = (sum[41:40] != 2'b00) ? '1 : sum[39:0];

    always_comb begin
        op_a = '0;
        op_b = '0;
        op_sub = 1'b0;
        case (r_state)
            S_SIZE: begin op_a = {9'd0, r_req}; op_b = {9'd0, r_am1}; end
            S_PTR:  begin op_a = {9'd0, r_nfa}; op_b = {9'd0, r_am1}; end
            S_WIN, S_AL0: begin op_a = {9'd0, r_nfa}; op_b = {8'd0, r_size}; end
            S_BUD0: begin op_a = {9'd0, r_own}; op_b = {1'b0, r_ext}; end
            S_BUD1: begin op_a = r_tmp; op_b = {8'd0, r_size}; end
            S_SCAN: begin op_a = {9'd0, slot_rd.start}; op_b = {9'd0, slot_rd.length}; end
            S_AL1:  begin op_a = {9'd0, r_own}; op_b = {8'd0, r_size}; end
            S_FREE: begin
                op_a = {9'd0, r_own}; op_b = {9'd0, slot_rd.length}; op_sub = 1'b1;
            end
            S_Q0:   begin op_a = {1'b0, r_ext}; op_b = {9'd0, r_fcharge}; end
            S_Q1:   begin op_a = {9'd0, r_own}; op_b = r_acct ? {1'b0, r_ext} : '0; end
            S_Q2:   begin op_a = {9'd0, r_budget}; op_b = r_tmp; op_sub = 1'b1; end
            S_CHG:  begin op_a = {1'b0, r_ext}; op_b = {9'd0, r_req}; end
            default: ;
        endcase
    end

    always_comb begin
        slot_wr.we     = (r_state == S_AL0);
        slot_wr.clr    = (r_state == S_FREE);
        slot_wr.start  = r_nfa;
        slot_wr.length = r_size[31:0];
        slot_wr.big    = (r_pcode != PCODE_SMALL);
    end

    assign in_ch.ready            = (r_state == S_IDLE) && !r_out_valid;
    assign out_ch.valid           = r_out_valid;
    assign out_ch.status          = r_status;
    assign out_ch.granted_addr    = r_granted;
    assign out_ch.budget_total    = r_total;
    assign out_ch.budget_avail    = r_avail;
    assign out_ch.found_page_size = r_psize;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acct      <= 1'b1;
            r_wend      <= RST_END;
            r_budget    <= RST_BUDGET;
            r_fcharge   <= RST_FOOTPRINT;
            r_nfa       <= RST_BASE;
            r_own       <= '0;
            r_ext       <= '0;
            r_fdone     <= 1'b0;
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_ACCT:      r_acct <= i_cfg_data[0];
                    // the window base only matters as the new bump pointer
                    REG_BASE:      r_nfa     <= i_cfg_data;
                    REG_END:       r_wend    <= i_cfg_data;
                    REG_BUDGET:    r_budget  <= i_cfg_data;
                    REG_FOOTPRINT: r_fcharge <= i_cfg_data;
                    default: ;
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        r_cmd     <= in_ch.cmd;
                        r_req     <= in_ch.req_size;
                        r_pcode   <= in_ch.page_code;
                        r_addr    <= in_ch.query_addr;
                        r_idx     <= '0;
                        r_status  <= ST_OK;
                        r_granted <= '0;
                        r_total   <= '0;
                        r_avail   <= '0;
                        r_psize   <= '0;
                        if (in_ch.cmd == CMD_RESERVE) begin
                            r_am1 <= (in_ch.align_bytes == '0) ? PAGE_SMALL_M1
                                                               : in_ch.align_bytes - 32'd1;
                        end else begin
                            r_am1 <= (in_ch.page_code == PCODE_SMALL) ? PAGE_SMALL_M1
                                                                      : PAGE_BIG_M1;
                        end
                        case (in_ch.cmd)
                            CMD_ALLOC, CMD_RESERVE: r_state <= S_SIZE;
                            CMD_FREE:    r_state <= S_SCAN;
                            CMD_LOOKUP: begin
                                r_psize <= PAGE_SMALL;
                                r_state <= S_SCAN;
                            end
                            CMD_QUERY:   r_state <= S_Q0;
                            CMD_CHARGE:  r_state <= S_CHG;
                            default: begin
                                r_status <= ST_INVAL;
                                r_state  <= S_DONE;
                            end
                        endcase
                    end
                end
                S_SIZE: begin
                    r_size  <= aligned;
                    r_state <= S_PTR;
                end
                S_PTR: begin
                    if (r_cmd == CMD_ALLOC && (r_pcode == PCODE_INVALID || r_size == '0)) begin
                        r_status <= ST_INVAL;
                        r_state  <= S_DONE;
                    end else if (aligned[32]) begin
                        r_status <= ST_NOMEM;
                        r_state  <= S_DONE;
                    end else begin
                        r_nfa   <= aligned[31:0];
                        r_state <= S_WIN;
                    end
                end
                S_WIN: begin
                    if (sum[33:0] > {2'b00, r_wend}) begin
                        r_status <= ST_NOMEM;
                        r_state  <= S_DONE;
                    end else if (r_cmd == CMD_RESERVE) begin
                        r_granted <= r_nfa;
                        r_nfa     <= sum[31:0];
                        r_state   <= S_DONE;
                    end else if (r_acct) begin
                        r_state <= S_BUD0;
                    end else begin
                        r_state <= S_SCAN;
                    end
                end
                S_BUD0: begin
                    r_tmp   <= sum[40:0];
                    r_state <= S_BUD1;
                end
                S_BUD1: begin
                    if (sum > {10'd0, r_budget}) begin
                        r_status <= ST_NOMEM;
                        r_state  <= S_DONE;
                    end else begin
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    case (r_cmd)
                        CMD_ALLOC: begin
                            if (!slot_rd.valid) begin
                                r_state <= S_AL0;
                            end else if (r_idx == LAST) begin
                                r_status <= ST_NOMEM;
                                r_state  <= S_DONE;
                            end else begin
                                r_idx <= r_idx + IW'(1);
                            end
                        end
                        CMD_FREE: begin
                            if (slot_rd.valid && slot_rd.start == r_addr) begin
                                r_state <= S_FREE;
                            end else if (r_idx == LAST) begin
                                r_status <= ST_INVAL;
                                r_state  <= S_DONE;
                            end else begin
                                r_idx <= r_idx + IW'(1);
                            end
                        end
                        default: begin
                            // page lookup: containing range
                            if (slot_rd.valid && r_addr >= slot_rd.start &&
                                {1'b0, r_addr} < sum[32:0]) begin
                                r_psize <= slot_rd.big ? PAGE_BIG : PAGE_SMALL;
                                r_state <= S_DONE;
                            end else if (r_idx == LAST) begin
                                r_state <= S_DONE;
                            end else begin
                                r_idx <= r_idx + IW'(1);
                            end
                        end
                    endcase
                end
                S_AL0: begin
                    r_granted <= r_nfa;
                    r_nfa     <= sum[31:0];
                    r_state   <= S_AL1;
                end
                S_AL1: begin
                    r_own   <= (sum[41:32] != '0) ? '1 : sum[31:0];
                    r_state <= S_DONE;
                end
                S_FREE: begin
                    r_own   <= (r_own >= slot_rd.length) ? sum[31:0] : '0;
                    r_state <= S_DONE;
                end
                S_Q0: begin
                    if (!r_fdone) begin
                        r_fdone <= 1'b1;
                        if (r_acct) begin
                            r_ext <= ext_sat;
                        end
                    end
                    r_state <= S_Q1;
                end
                S_Q1: begin
                    r_tmp   <= sum[40:0];
                    r_state <= S_Q2;
                end
                S_Q2: begin
                    r_total <= r_budget;
                    r_avail <= (r_tmp >= {9'd0, r_budget}) ? '0 : sum[31:0];
                    r_state <= S_DONE;
                end
                S_CHG: begin
                    if (r_acct) begin
                        r_ext <= ext_sat;
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    r_out_valid <= 1'b1;
                    r_state     <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

/* sv/bra_slot_table.sv */
// slot table: valid flags plus start, length and page kind per slot
// depends on bra_pkg
`default_nettype none
module bra_slot_table
    import bra_pkg::*;
#(
    parameter int unsigned SLOTS = SLOTS_DEF,
    localparam int unsigned IW = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic [IW-1:0] i_idx,
    input  wire t_slot_wr      i_wr,
    output t_slot_rd           o_rd
);
    logic [SLOTS-1:0] r_valid;
    logic [31:0]      r_start  [SLOTS];
    logic [31:0]      r_length [SLOTS];
    logic             r_big    [SLOTS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr.we) begin
            r_valid[i_idx] <= 1'b1;
        end else if (i_wr.clr) begin
            r_valid[i_idx] <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_start[i_idx]  <= i_wr.start;
            r_length[i_idx] <= i_wr.length;
            r_big[i_idx]    <= i_wr.big;
        end
    end

    assign o_rd = {r_valid[i_idx], r_start[i_idx], r_length[i_idx], r_big[i_idx]};
endmodule
`default_nettype wire

/* dv/bump_region_allocator_test.sv */
// testbench for bump_region_allocator: directed and random commands against a predictor
// depends on bra_pkg, bra_in_if, bra_out_if and the bump_region_allocator rtl
`default_nettype none
module bump_region_allocator_test;
    import bra_pkg::*;

    localparam logic [2:0]  CMD_UNDEF_LO = 3'd6;
    localparam logic [2:0]  CMD_UNDEF_HI = 3'd7;
    localparam logic [1:0]  PCODE_DEFAULT = 2'd0;
    localparam logic [1:0]  PCODE_BIG = 2'd1;
    localparam logic [63:0] LEDGER_MAX = 64'hFF_FFFF_FFFF;
    localparam logic [63:0] WORD_MAX = 64'hFFFF_FFFF;
    localparam int          NSLOTS = SLOTS_DEF;

    typedef struct {
        logic [2:0]  cmd;
        logic [31:0] req_size;
        logic [1:0]  page_code;
        logic [31:0] align_bytes;
        logic [31:0] query_addr;
    } cmd_beat_t;

    typedef struct {
        logic [1:0]  status;
        logic [31:0] granted_addr;
        logic [31:0] budget_total;
        logic [31:0] budget_avail;
        logic [20:0] found_page_size;
    } rsp_beat_t;

    class alloc_scoreboard;
        // configuration
        bit          acct_en;
        logic [31:0] win_base, win_end, budget, footprint;
        // allocator state
        logic [31:0] bump_ptr, own_bytes;
        logic [63:0] ledger;
        bit          fp_charged;
        bit          slot_used[NSLOTS];
        logic [31:0] slot_base[NSLOTS];
        logic [31:0] slot_len[NSLOTS];
        bit          slot_big[NSLOTS];
        rsp_beat_t   expected_rsp[$];
        int          errors, n_ok, n_inval, n_nomem;

        function new();
            acct_en = 1'b1;
            win_base = RST_BASE;
            win_end = RST_END;
            budget = RST_BUDGET;
            footprint = RST_FOOTPRINT;
            bump_ptr = RST_BASE;
            own_bytes = '0;
            ledger = '0;
            fp_charged = 1'b0;
            foreach (slot_used[i]) slot_used[i] = 1'b0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [31:0] val);
            case (idx)
                REG_ACCT: acct_en = val[0];
                REG_BASE: begin
                    win_base = val;
                    bump_ptr = val;
                end
                REG_END: win_end = val;
                REG_BUDGET: budget = val;
                REG_FOOTPRINT: footprint = val;
                default: ;
            endcase
        endfunction

        function logic [63:0] round_up(logic [63:0] x, logic [63:0] a);
            return (x + a - 64'd1) & ~(a - 64'd1);
        endfunction

        function void add_ledger(logic [63:0] bytes);
            if (acct_en) begin
                ledger = ledger + bytes;
                if (ledger > LEDGER_MAX) ledger = LEDGER_MAX;
            end
        endfunction

        // aligns the bump pointer, zero if it no longer fits in 32 bits
        function bit bump_align(logic [63:0] a);
            logic [63:0] p;
            p = round_up({32'b0, bump_ptr}, a);
            if (p > WORD_MAX) return 1'b0;
            bump_ptr = p[31:0];
            return 1'b1;
        endfunction

        function void note_cmd(cmd_beat_t c);
            rsp_beat_t   r;
            logic [63:0] a, size, used, s;
            bit          big;
            int          slot;
            r = '{default: '0};
            slot = -1;
            case (c.cmd)
                CMD_ALLOC: begin
                    big = (c.page_code != PCODE_SMALL);
                    a = big ? {43'b0, PAGE_BIG} : {43'b0, PAGE_SMALL};
                    size = round_up({32'b0, c.req_size}, a);
                    if (c.page_code == PCODE_INVALID || size == 0) begin
                        r.status = ST_INVAL;
                    end else if (!bump_align(a)) begin
                        r.status = ST_NOMEM;
                    end else if ({32'b0, bump_ptr} + size > {32'b0, win_end}) begin
                        r.status = ST_NOMEM;
                    end else if (acct_en && {32'b0, own_bytes} + ledger + size > budget) begin
                        r.status = ST_NOMEM;
                    end else begin
                        for (int i = 0; i < NSLOTS; i++)
                            if (slot < 0 && !slot_used[i]) slot = i;
                        if (slot < 0) begin
                            r.status = ST_NOMEM;
                        end else begin
                            r.granted_addr = bump_ptr;
                            bump_ptr = bump_ptr + size[31:0];
                            s = {32'b0, own_bytes} + size;
                            own_bytes = (s > WORD_MAX) ? WORD_MAX[31:0] : s[31:0];
                            slot_used[slot] = 1'b1;
                            slot_base[slot] = r.granted_addr;
                            slot_len[slot] = size[31:0];
                            slot_big[slot] = big;
                        end
                    end
                end
                CMD_FREE: begin
                    r.status = ST_INVAL;
                    for (int i = 0; i < NSLOTS; i++) begin
                        if (slot < 0 && slot_used[i] && slot_base[i] == c.query_addr) begin
                            slot = i;
                            own_bytes = (own_bytes >= slot_len[i]) ? own_bytes - slot_len[i] : '0;
                            slot_used[i] = 1'b0;
                            r.status = ST_OK;
                        end
                    end
                end
                CMD_QUERY: begin
                    if (!fp_charged) begin
                        fp_charged = 1'b1;
                        add_ledger({32'b0, footprint});
                    end
                    r.budget_total = budget;
                    used = {32'b0, own_bytes} + (acct_en ? ledger : 64'd0);
                    s = (used >= budget) ? 64'd0 : {32'b0, budget} - used;
                    r.budget_avail = s[31:0];
                end
                CMD_LOOKUP: begin
                    r.found_page_size = PAGE_SMALL;
                    for (int i = 0; i < NSLOTS; i++) begin
                        if (slot < 0 && slot_used[i] && c.query_addr >= slot_base[i] &&
                            {32'b0, c.query_addr} < {32'b0, slot_base[i]} + slot_len[i]) begin
                            slot = i;
                            r.found_page_size = slot_big[i] ? PAGE_BIG : PAGE_SMALL;
                        end
                    end
                end
                CMD_RESERVE: begin
                    a = (c.align_bytes != 0) ? {32'b0, c.align_bytes} : {43'b0, PAGE_SMALL};
                    size = round_up({32'b0, c.req_size}, a);
                    if (!bump_align(a)) begin
                        r.status = ST_NOMEM;
                    end else if ({32'b0, bump_ptr} + size > {32'b0, win_end}) begin
                        r.status = ST_NOMEM;
                    end else begin
                        r.granted_addr = bump_ptr;
                        bump_ptr = bump_ptr + size[31:0];
                    end
                end
                CMD_CHARGE: add_ledger({32'b0, c.req_size});
                default: r.status = ST_INVAL;
            endcase
            expected_rsp.push_back(r);
        endfunction

        function void check_rsp(rsp_beat_t got);
            rsp_beat_t w;
            if (expected_rsp.size() == 0) begin
                $error("result beat with nothing expected, status %0d", got.status);
                errors++;
                return;
            end
            w = expected_rsp.pop_front();
            case (w.status)
                ST_OK: n_ok++;
                ST_INVAL: n_inval++;
                default: n_nomem++;
            endcase
            if (got.status !== w.status) begin
                $error("status: expected %0d, got %0d", w.status, got.status);
                errors++;
            end
            if (got.granted_addr !== w.granted_addr) begin
                $error("granted_addr: expected %h, got %h", w.granted_addr, got.granted_addr);
                errors++;
            end
            if (got.budget_total !== w.budget_total) begin
                $error("budget_total: expected %h, got %h", w.budget_total, got.budget_total);
                errors++;
            end
            if (got.budget_avail !== w.budget_avail) begin
                $error("budget_avail: expected %h, got %h", w.budget_avail, got.budget_avail);
                errors++;
            end
            if (got.found_page_size !== w.found_page_size) begin
                $error("found_page_size: expected %h, got %h", w.found_page_size,
                       got.found_page_size);
                errors++;
            end
        endfunction

        // random live slot, for frees and lookups that hit
        function bit pick_live(output logic [31:0] base, output logic [31:0] len);
            int live[$];
            int k;
            for (int i = 0; i < NSLOTS; i++)
                if (slot_used[i]) live.push_back(i);
            base = '0;
            len = '0;
            if (live.size() == 0) return 1'b0;
            k = live[$urandom_range(0, live.size() - 1)];
            base = slot_base[k];
            len = slot_len[k];
            return 1'b1;
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [31:0] i_cfg_data;

    bra_in_if  in_ch();
    bra_out_if out_ch();

    bump_region_allocator DUT (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    alloc_scoreboard sb;
    bit squeeze_req;
    int sent;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    initial begin
        #20_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // result side: stall pattern of its own, plus one long hold-off on request
    initial begin
        int hold_cnt;
        int cyc;
        rsp_beat_t got;
        hold_cnt = 0;
        cyc = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            cyc++;
            if (out_ch.valid && out_ch.ready) begin
                got.status = out_ch.status;
                got.granted_addr = out_ch.granted_addr;
                got.budget_total = out_ch.budget_total;
                got.budget_avail = out_ch.budget_avail;
                got.found_page_size = out_ch.found_page_size;
                sb.check_rsp(got);
            end
            if (squeeze_req) begin
                squeeze_req = 1'b0;
                hold_cnt = 400;
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                out_ch.ready <= 1'b0;
            end else begin
                case ((cyc / 97) % 4)
                    0: out_ch.ready <= 1'b1;
                    1: out_ch.ready <= ($urandom_range(0, 3) != 0);
                    2: out_ch.ready <= cyc[1];
                    default: out_ch.ready <= ($urandom_range(0, 4) == 0);
                endcase
            end
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        sb.set_reg(idx, val);
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        while (sb.expected_rsp.size() != 0 && guard < 100_000) begin
            @(posedge i_clk);
            guard++;
        end
        // unless the guard ran out, no command is in flight now; let the sequencer settle
        repeat (60) @(posedge i_clk);
    endtask

    task automatic put_cmd(cmd_beat_t c);
        in_ch.valid <= 1'b1;
        in_ch.cmd <= c.cmd;
        in_ch.req_size <= c.req_size;
        in_ch.page_code <= c.page_code;
        in_ch.align_bytes <= c.align_bytes;
        in_ch.query_addr <= c.query_addr;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        sb.note_cmd(c);
        sent++;
    endtask

    function automatic cmd_beat_t mk(logic [2:0] cmd, logic [31:0] size, logic [1:0] pc,
                                     logic [31:0] al, logic [31:0] addr);
        cmd_beat_t c;
        c.cmd = cmd;
        c.req_size = size;
        c.page_code = pc;
        c.align_bytes = al;
        c.query_addr = addr;
        return c;
    endfunction

    function automatic logic [31:0] rand_size();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick == 0) return $urandom();
        if (pick == 1) return 32'd0;
        if (pick < 5) return $urandom_range(1, 32'h0001_0000);
        return $urandom_range(1, 32'h0030_0000);
    endfunction

    function automatic cmd_beat_t rand_cmd();
        cmd_beat_t   c;
        logic [31:0] base, len;
        int          pick;
        c = mk(CMD_ALLOC, rand_size(), 2'($urandom_range(0, 3)), $urandom(), $urandom());
        if ($urandom_range(0, 9) != 0) c.page_code = 2'($urandom_range(0, 2));
        pick = $urandom_range(0, 99);
        if (pick < 35) begin
            c.cmd = CMD_ALLOC;
        end else if (pick < 55) begin
            c.cmd = CMD_FREE;
            if ($urandom_range(0, 5) != 0 && sb.pick_live(base, len)) c.query_addr = base;
        end else if (pick < 62) begin
            c.cmd = CMD_QUERY;
        end else if (pick < 77) begin
            c.cmd = CMD_LOOKUP;
            if ($urandom_range(0, 3) != 0 && sb.pick_live(base, len))
                c.query_addr = base + $urandom_range(0, len - 1);
            else if ($urandom_range(0, 1) != 0)
                c.query_addr = sb.win_base + $urandom_range(0, 32'h0400_0000);
        end else if (pick < 87) begin
            c.cmd = CMD_RESERVE;
            case ($urandom_range(0, 4))
                0, 1: c.align_bytes = '0;
                2: c.align_bytes = 32'd1 << $urandom_range(0, 24);
                3: c.align_bytes = $urandom_range(1, 32'h0003_0000);
                default: c.align_bytes = $urandom();
            endcase
        end else if (pick < 96) begin
            c.cmd = CMD_CHARGE;
            if ($urandom_range(0, 5) != 0) c.req_size = $urandom_range(0, 32'h0020_0000);
        end else begin
            c.cmd = $urandom_range(0, 1) ? CMD_UNDEF_HI : CMD_UNDEF_LO;
        end
        return c;
    endfunction

    initial begin
        int          phase_items[6];
        int          burst_left;
        logic [31:0] base, len, rb;
        cmd_beat_t   c;

        sb = new();
        squeeze_req = 1'b0;
        sent = 0;
        phase_items = '{178, 190, 60, 200, 200, 200};
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_idx <= '0;
        i_cfg_data <= '0;
        in_ch.valid <= 1'b0;
        in_ch.cmd <= '0;
        in_ch.req_size <= '0;
        in_ch.page_code <= '0;
        in_ch.align_bytes <= '0;
        in_ch.query_addr <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: each command, page codes, zero and full sizes, misses, first query
        put_cmd(mk(CMD_QUERY, '0, '0, '0, '0));
        put_cmd(mk(CMD_QUERY, '0, '0, '0, '0));
        put_cmd(mk(CMD_ALLOC, 32'd1, PCODE_DEFAULT, '0, '0));
        put_cmd(mk(CMD_ALLOC, 32'h0010_0000, PCODE_BIG, '0, '0));
        put_cmd(mk(CMD_ALLOC, 32'd5, PCODE_SMALL, '0, '0));
        put_cmd(mk(CMD_ALLOC, 32'd5, PCODE_INVALID, '0, '0));
        put_cmd(mk(CMD_ALLOC, 32'd0, PCODE_BIG, '0, '0));
        put_cmd(mk(CMD_ALLOC, 32'hFFFF_FFFF, PCODE_SMALL, '0, '0));
        put_cmd(mk(CMD_ALLOC, 32'hFFFF_FFFF, PCODE_DEFAULT, '0, '0));
        put_cmd(mk(CMD_LOOKUP, '0, '0, '0, RST_BASE + 32'h0000_0010));
        put_cmd(mk(CMD_LOOKUP, '0, '0, '0, RST_BASE + 32'h0020_0000));
        put_cmd(mk(CMD_LOOKUP, '0, '0, '0, 32'hFFFF_FFFF));
        put_cmd(mk(CMD_FREE, '0, '0, '0, RST_BASE));
        put_cmd(mk(CMD_FREE, '0, '0, '0, RST_BASE));
        put_cmd(mk(CMD_RESERVE, 32'd0, '0, 32'd0, '0));
        put_cmd(mk(CMD_RESERVE, 32'd7, '0, 32'd3, '0));
        put_cmd(mk(CMD_RESERVE, 32'd1, '0, 32'hFFFF_FFFF, '0));
        put_cmd(mk(CMD_RESERVE, 32'hFFFF_FFFF, '0, 32'd1, '0));
        put_cmd(mk(CMD_CHARGE, 32'hFFFF_FFFF, '0, '0, '0));
        put_cmd(mk(CMD_ALLOC, 32'd1, PCODE_SMALL, '0, '0));
        put_cmd(mk(CMD_QUERY, '0, '0, '0, '0));
        put_cmd(mk(CMD_UNDEF_LO, 32'hFFFF_FFFF, 2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        put_cmd(mk(CMD_UNDEF_HI, '0, '0, '0, '0));
        in_ch.valid <= 1'b0;

        for (int ph = 0; ph < 6; ph++) begin
            if (ph > 0) begin
                drain();
                case (ph)
                    1: begin
                        write_reg(REG_ACCT, 32'd1);
                        write_reg(REG_BASE, 32'h1000_0000);
                        write_reg(REG_END, 32'h3000_0000);
                        write_reg(REG_BUDGET, 32'hFFFF_FFFF);
                        write_reg(REG_FOOTPRINT, 32'd0);
                    end
                    2: begin
                        write_reg(REG_ACCT, 32'd0);
                        write_reg(REG_BASE, 32'd0);
                        write_reg(REG_END, 32'hFFFF_FFFF);
                        write_reg(REG_BUDGET, 32'd0);
                        write_reg(REG_FOOTPRINT, 32'hFFFF_FFFF);
                    end
                    3: begin
                        // pointer near the top: aligning it to a big page overflows 32 bits
                        write_reg(REG_ACCT, 32'd1);
                        write_reg(REG_BASE, 32'hFFF0_0001);
                        write_reg(REG_END, 32'hFFFF_FFFF);
                        write_reg(REG_BUDGET, 32'h0800_0000);
                    end
                    4: begin
                        write_reg(REG_ACCT, 32'd0);
                        write_reg(REG_BASE, 32'h2000_0000);
                        write_reg(REG_END, 32'h2400_0000);
                        write_reg(REG_BUDGET, $urandom_range(0, 32'h0300_0000));
                    end
                    default: begin
                        rb = $urandom() & 32'hFFF0_0000;
                        write_reg(REG_ACCT, 32'($urandom_range(0, 1)));
                        write_reg(REG_BASE, rb);
                        write_reg(REG_END, rb + $urandom_range(32'h0080_0000, 32'h1000_0000));
                        write_reg(REG_BUDGET, $urandom());
                        write_reg(REG_FOOTPRINT, $urandom_range(0, 32'h0100_0000));
                    end
                endcase
                i_cfg_we <= 1'b0;
                @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 20);
            for (int n = 0; n < phase_items[ph]; n++) begin
                put_cmd(rand_cmd());
                if (ph == 1 && n == 60) squeeze_req = 1'b1;
                burst_left--;
                if (burst_left == 0) begin
                    burst_left = (ph == 3) ? 200 : $urandom_range(1, 20);
                    in_ch.valid <= 1'b0;
                    repeat ($urandom_range(1, 15)) @(posedge i_clk);
                end
            end
            in_ch.valid <= 1'b0;
        end

        drain();
        $display("commands sent: %0d, results ok %0d, invalid %0d, out of memory %0d",
                 sent, sb.n_ok, sb.n_inval, sb.n_nomem);
        $display("six configuration phases incl. window overflow and accounting off");
        if (sb.errors == 0 && sb.expected_rsp.size() == 0) begin
            $display("TB_OK");
        end else begin
            if (sb.expected_rsp.size() != 0)
                $error("%0d expected results never arrived", sb.expected_rsp.size());
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
`default_nettype wire

/* sim.f */
sv/bra_pkg.sv
sv/bra_in_if.sv
sv/bra_out_if.sv
sv/bra_slot_table.sv
sv/bump_region_allocator.sv
dv/bump_region_allocator_test.sv
